/* sv/mpct_pkg.sv */
// Package for the mouse packet cursor tracker: codes, state and result types,
// and the fixed click region table. No dependencies.
`default_nettype none

package mpct_pkg;

  localparam int CoordW  = 10;
  localparam int ByteW   = 8;
  localparam int CodeW   = 4;
  localparam int CfgIdxW = 2;
  // Proposed coordinates span -256..1279, so two bits above the coordinate
  localparam int PropW   = CoordW + 2;

  // Request types
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_POLL = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_EDGE_MAX_X = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_EDGE_MAX_Y = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_EDGE_MIN   = 2'd2;

  localparam logic [CoordW-1:0] EDGE_MAX_X_RST = 10'd793;
  localparam logic [CoordW-1:0] EDGE_MAX_Y_RST = 10'd592;
  localparam logic [CoordW-1:0] EDGE_MIN_RST   = 10'd1;

  localparam logic [ByteW-1:0] CLICK_STATUS = 8'd9;
  localparam int XSignBit = 4;
  localparam int YSignBit = 5;

  localparam logic [CodeW-1:0] SEL_NONE = 4'd0;

  typedef enum logic [1:0] {
    PH_STATUS = 2'd0,
    PH_X      = 2'd1,
    PH_Y      = 2'd2
  } phase_t;

  typedef struct packed {
    phase_t              phase;
    logic [ByteW-1:0]    held_status;
    logic [CoordW-1:0]   held_dx;
    logic [CoordW-1:0]   pos_x;
    logic [CoordW-1:0]   pos_y;
    logic [CodeW-1:0]    pending;
  } track_state_t;

  typedef struct packed {
    logic [CoordW-1:0] max_x;
    logic [CoordW-1:0] max_y;
    logic [CoordW-1:0] min;
  } edges_t;

  typedef struct packed {
    logic [CoordW-1:0] cursor_x;
    logic [CoordW-1:0] cursor_y;
    logic              moved;
    logic [CodeW-1:0]  selection_code;
  } result_t;

  // Click regions, highest priority first; code is position + 1
  localparam int RegionCount = 11;
  typedef logic [CoordW-1:0] coord_list_t [RegionCount];
  localparam coord_list_t RegX0 = '{10'd50,  10'd50,  10'd150, 10'd300, 10'd300, 10'd400,
                                    10'd550, 10'd550, 10'd650, 10'd50,  10'd425};
  localparam coord_list_t RegX1 = '{10'd250, 10'd150, 10'd250, 10'd500, 10'd400, 10'd500,
                                    10'd750, 10'd650, 10'd750, 10'd375, 10'd750};
  localparam coord_list_t RegY0 = '{10'd50,  10'd150, 10'd150, 10'd50,  10'd150, 10'd150,
                                    10'd50,  10'd150, 10'd150, 10'd250, 10'd250};
  localparam coord_list_t RegY1 = '{10'd150, 10'd200, 10'd200, 10'd150, 10'd200, 10'd200,
                                    10'd150, 10'd200, 10'd200, 10'd550, 10'd550};

  // First region containing the point, or SEL_NONE
  function automatic logic [CodeW-1:0] region_code(input logic [CoordW-1:0] x,
                                                   input logic [CoordW-1:0] y);
    logic [CodeW-1:0] code;
    code = SEL_NONE;
    for (int i = RegionCount - 1; i >= 0; i--) begin
      if (y >= RegY0[i] && y <= RegY1[i] && x >= RegX0[i] && x <= RegX1[i]) begin
        code = CodeW'(i + 1);
      end
    end
    return code;
  endfunction

endpackage

`default_nettype wire

/* sv/mpct_in_if.sv */
// Input channel of the cursor tracker: request type and mouse byte.
// Depends on mpct_pkg.
`default_nettype none

interface mpct_in_if;
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [mpct_pkg::ByteW-1:0] data_byte;

  modport source (output valid, req_type, data_byte, input ready);
  modport sink   (input valid, req_type, data_byte, output ready);
endinterface

`default_nettype wire

/* sv/mpct_out_if.sv */
// Result channel of the cursor tracker: cursor, move flag, selection code.
// Depends on mpct_pkg.
`default_nettype none

interface mpct_out_if;
  logic                        valid;
  logic                        ready;
  logic [mpct_pkg::CoordW-1:0] cursor_x;
  logic [mpct_pkg::CoordW-1:0] cursor_y;
  logic                        moved;
  logic [mpct_pkg::CodeW-1:0]  selection_code;

  modport source (output valid, cursor_x, cursor_y, moved, selection_code, input ready);
  modport sink   (input valid, cursor_x, cursor_y, moved, selection_code, output ready);
endinterface

`default_nettype wire

/* sv/mpct_cfg_if.sv */
// Configuration write channel of the cursor tracker: register index and data.
// Depends on mpct_pkg.
`default_nettype none

interface mpct_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [mpct_pkg::CfgIdxW-1:0] reg_index;
  logic [mpct_pkg::CoordW-1:0]  wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

/* sv/mpct_step.sv */
// Next-state and result logic for one item of the cursor tracker.
// Depends on mpct_pkg.
`default_nettype none

module mpct_step (
  input  mpct_pkg::track_state_t      cur,
  input  mpct_pkg::edges_t            edges,
  input  logic                        req_type,
  input  logic [mpct_pkg::ByteW-1:0]  data_byte,
  output mpct_pkg::track_state_t      nxt,
  output mpct_pkg::result_t           res
);
  import mpct_pkg::*;

  logic signed [PropW-1:0] prop_x;
  logic signed [PropW-1:0] prop_y;
  logic signed [PropW-1:0] min_s;
  logic signed [PropW-1:0] max_x_s;
  logic signed [PropW-1:0] max_y_s;
  logic                    y_sign;
  logic                    move_ok;
  logic [CodeW-1:0]        click_code;

  // Propose the move: x from the held motion, y negated so it grows downward
  assign y_sign  = cur.held_status[YSignBit];
  assign prop_x  = $signed({2'b00, cur.pos_x}) +
                   $signed({{2{cur.held_dx[CoordW-1]}}, cur.held_dx});
  assign prop_y  = $signed({2'b00, cur.pos_y}) -
                   $signed({{(PropW-ByteW-1){y_sign}}, y_sign, data_byte});
  assign min_s   = $signed({2'b00, edges.min});
  assign max_x_s = $signed({2'b00, edges.max_x});
  assign max_y_s = $signed({2'b00, edges.max_y});
  assign move_ok = (prop_x > min_s) && (prop_x < max_x_s) &&
                   (prop_y > min_s) && (prop_y < max_y_s);

  // Region hit at the cursor held before this packet's motion
  assign click_code = region_code(cur.pos_x, cur.pos_y);

  // Advance the packet phase and cursor
  always_comb begin
    nxt                = cur;
    res.moved          = 1'b0;
    res.selection_code = SEL_NONE;
    if (req_type == REQ_POLL) begin
      res.selection_code = cur.pending;
      nxt.pending        = SEL_NONE;
    end else begin
      unique case (cur.phase)
        PH_STATUS: begin
          nxt.held_status = data_byte;
          if (data_byte == CLICK_STATUS && click_code != SEL_NONE) begin
            nxt.pending = click_code;
          end
          nxt.phase = PH_X;
        end
        PH_X: begin
          nxt.held_dx = {{2{cur.held_status[XSignBit]}}, data_byte};
          nxt.phase   = PH_Y;
        end
        default: begin
          if (move_ok) begin
            nxt.pos_x = prop_x[CoordW-1:0];
            nxt.pos_y = prop_y[CoordW-1:0];
            res.moved = 1'b1;
          end
          nxt.phase = PH_STATUS;
        end
      endcase
    end
    res.cursor_x = nxt.pos_x;
    res.cursor_y = nxt.pos_y;
  end

endmodule

`default_nettype wire

/* sv/mouse_packet_cursor_tracker_unit.sv */
// Mouse packet cursor tracker: input register, one step of decode logic, result register.
// An accepted item waits in the input register until the result register is free, then its result is registered.
// Throughput: one item per cycle; a held result holds the input register, which then drops ready.
// Reset: edges return to 793/592/1, cursor to 0,0, phase to status, no pending code.
// Depends on mpct_pkg, mpct_in_if, mpct_out_if, mpct_cfg_if and mpct_step.
`default_nettype none

module mouse_packet_cursor_tracker_unit (
  input  logic        clk,
  input  logic        rst,
  mpct_in_if.sink     pkt_in,
  mpct_out_if.source  res_out,
  mpct_cfg_if.sink    cfg
);
  import mpct_pkg::*;

  track_state_t     state;
  track_state_t     state_next;
  edges_t           edges;
  result_t          step_res;
  result_t          out_res;
  logic             out_valid;
  logic             s1_valid;
  logic             s1_req;
  logic [ByteW-1:0] s1_byte;
  logic             advance;

  // Move the input register into the result register when it is free
  assign advance      = s1_valid && (!out_valid || res_out.ready);
  assign pkt_in.ready = !s1_valid || advance;
  assign cfg.ready    = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pkt_in.ready) begin
      s1_valid <= pkt_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_in.valid && pkt_in.ready) begin
      s1_req  <= pkt_in.req_type;
      s1_byte <= pkt_in.data_byte;
    end
  end

  mpct_step u_step (
    .cur       (state),
    .edges     (edges),
    .req_type  (s1_req),
    .data_byte (s1_byte),
    .nxt       (state_next),
    .res       (step_res)
  );

  // Tracker state, updated as each item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: PH_STATUS, held_status: '0, held_dx: '0,
                 pos_x: '0, pos_y: '0, pending: SEL_NONE};
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Edge registers
  always_ff @(posedge clk) begin
    if (rst) begin
      edges <= '{max_x: EDGE_MAX_X_RST, max_y: EDGE_MAX_Y_RST, min: EDGE_MIN_RST};
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.reg_index)
        CFG_EDGE_MAX_X: edges.max_x <= cfg.wdata;
        CFG_EDGE_MAX_Y: edges.max_y <= cfg.wdata;
        CFG_EDGE_MIN:   edges.min   <= cfg.wdata;
        default:        edges       <= edges;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign res_out.valid          = out_valid;
  assign res_out.cursor_x       = out_res.cursor_x;
  assign res_out.cursor_y       = out_res.cursor_y;
  assign res_out.moved          = out_res.moved;
  assign res_out.selection_code = out_res.selection_code;

  // A poll leaves no pending code behind
  a_poll_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_req == REQ_POLL) |=> (state.pending == SEL_NONE))
    else $error("pending selection survived a poll");

  // A result never both moves and reports a selection
  a_move_or_sel: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_res.moved && out_res.selection_code != SEL_NONE))
    else $error("result both moved and carried a selection");

  // The cursor only changes when a result reports a move
  a_cursor_move: assert property (@(posedge clk) disable iff (rst)
    (advance && !step_res.moved) |=> ($stable(state.pos_x) && $stable(state.pos_y)))
    else $error("cursor changed without a move");

  // Pending code stays within the region list
  a_pending_range: assert property (@(posedge clk) disable iff (rst)
    state.pending <= CodeW'(RegionCount))
    else $error("pending selection out of range");

endmodule

`default_nettype wire

/* dv/tb_mouse_packet_cursor_tracker_unit.sv */
// Self-checking testbench for the mouse packet cursor tracker: directed packets, edge
// register settings and random traffic under idling, checked against an in-bench predictor.
// Depends on mpct_pkg, mpct_in_if, mpct_out_if, mpct_cfg_if and the tracker RTL.
`default_nettype none

module tb_mouse_packet_cursor_tracker_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mpct_pkg::*;

  localparam int StallLimit   = 2000;
  localparam int ReportLimit  = 10;
  localparam int RegionTotal  = 11;

  // Click rectangles, highest priority first; the code is position + 1
  localparam int BoxX0 [RegionTotal] = '{50, 50, 150, 300, 300, 400, 550, 550, 650, 50, 425};
  localparam int BoxX1 [RegionTotal] = '{250, 150, 250, 500, 400, 500, 750, 650, 750, 375, 750};
  localparam int BoxY0 [RegionTotal] = '{50, 150, 150, 50, 150, 150, 50, 150, 150, 250, 250};
  localparam int BoxY1 [RegionTotal] = '{150, 200, 200, 150, 200, 200, 150, 200, 200, 550, 550};

  logic clk = 1'b0;
  logic rst;

  mpct_in_if  pkt_if ();
  mpct_out_if res_if ();
  mpct_cfg_if cfg_if ();

  mouse_packet_cursor_tracker_unit dut (
    .clk     (clk),
    .rst     (rst),
    .pkt_in  (pkt_if),
    .res_out (res_if),
    .cfg     (cfg_if)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Predicted tracker state
  phase_t             trk_phase;
  logic [ByteW-1:0]   trk_status;
  logic [CoordW-1:0]  trk_dx;
  logic [CoordW-1:0]  trk_x;
  logic [CoordW-1:0]  trk_y;
  logic [CodeW-1:0]   trk_pending;
  edges_t             trk_edges;

  result_t cursor_reports_q [$];
  int      cursor_errors = 0;
  int      reports_seen  = 0;
  int      quiet_cycles  = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;

  // First rectangle holding the point, or no selection
  function automatic logic [CodeW-1:0] click_region(input logic [CoordW-1:0] x,
                                                    input logic [CoordW-1:0] y);
    for (int i = 0; i < RegionTotal; i++) begin
      if (int'(y) >= BoxY0[i] && int'(y) <= BoxY1[i] &&
          int'(x) >= BoxX0[i] && int'(x) <= BoxX1[i]) begin
        return CodeW'(i + 1);
      end
    end
    return SEL_NONE;
  endfunction

  // Advance the predicted state by one item and return the report it causes
  function automatic result_t track_cursor_step(input logic req, input logic [ByteW-1:0] b);
    result_t          r;
    int               nx;
    int               ny;
    int               dy;
    logic [CodeW-1:0] hit;
    r.moved = 1'b0;
    r.selection_code = SEL_NONE;
    if (req == REQ_POLL) begin
      r.selection_code = trk_pending;
      trk_pending = SEL_NONE;
    end else begin
      case (trk_phase)
        PH_STATUS: begin
          trk_status = b;
          // a click is tested at the cursor held before this packet's motion
          if (b == CLICK_STATUS) begin
            hit = click_region(trk_x, trk_y);
            if (hit != SEL_NONE) trk_pending = hit;
          end
          trk_phase = PH_X;
        end
        PH_X: begin
          trk_dx = CoordW'(int'(b) - (trk_status[XSignBit] ? 256 : 0));
          trk_phase = PH_Y;
        end
        default: begin
          // y grows downward, so the motion is negated
          dy = (trk_status[YSignBit] ? 256 : 0) - int'(b);
          nx = int'(trk_x) + int'($signed(trk_dx));
          ny = int'(trk_y) + dy;
          if (nx > int'(trk_edges.min) && nx < int'(trk_edges.max_x) &&
              ny > int'(trk_edges.min) && ny < int'(trk_edges.max_y)) begin
            trk_x = CoordW'(nx);
            trk_y = CoordW'(ny);
            r.moved = 1'b1;
          end
          trk_phase = PH_STATUS;
        end
      endcase
    end
    r.cursor_x = trk_x;
    r.cursor_y = trk_y;
    return r;
  endfunction

  // Predict on every accepted item, check every accepted report, watch for a hang
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      trk_phase   = PH_STATUS;
      trk_status  = '0;
      trk_dx      = '0;
      trk_x       = '0;
      trk_y       = '0;
      trk_pending = SEL_NONE;
      trk_edges.max_x = EDGE_MAX_X_RST;
      trk_edges.max_y = EDGE_MAX_Y_RST;
      trk_edges.min   = EDGE_MIN_RST;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.reg_index)
          CFG_EDGE_MAX_X: trk_edges.max_x = cfg_if.wdata;
          CFG_EDGE_MAX_Y: trk_edges.max_y = cfg_if.wdata;
          CFG_EDGE_MIN:   trk_edges.min   = cfg_if.wdata;
          default: ;
        endcase
      end
      if (pkt_if.valid && pkt_if.ready) begin
        cursor_reports_q.push_back(track_cursor_step(pkt_if.req_type, pkt_if.data_byte));
      end
      if (res_if.valid && res_if.ready) begin
        got.cursor_x       = res_if.cursor_x;
        got.cursor_y       = res_if.cursor_y;
        got.moved          = res_if.moved;
        got.selection_code = res_if.selection_code;
        if (cursor_reports_q.size() == 0) begin
          cursor_errors++;
          if (cursor_errors <= ReportLimit) begin
            $display("report %0d with nothing expected: x=%0d y=%0d moved=%0b sel=%0d",
                     reports_seen, got.cursor_x, got.cursor_y, got.moved,
                     got.selection_code);
          end
        end else begin
          want = cursor_reports_q.pop_front();
          if (got.cursor_x !== want.cursor_x || got.cursor_y !== want.cursor_y ||
              got.moved !== want.moved || got.selection_code !== want.selection_code) begin
            cursor_errors++;
            if (cursor_errors <= ReportLimit) begin
              $display("report %0d: expected x=%0d y=%0d moved=%0b sel=%0d,",
                       reports_seen, want.cursor_x, want.cursor_y, want.moved,
                       want.selection_code,
                       " got x=%0d y=%0d moved=%0b sel=%0d",
                       got.cursor_x, got.cursor_y, got.moved, got.selection_code);
            end
          end
        end
        reports_seen++;
      end
    end
    if ((pkt_if.valid && pkt_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offer one item, idling first at random, and return at the edge that takes it
  task automatic send_item(input logic req, input logic [ByteW-1:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      pkt_if.valid <= 1'b0;
      @(negedge clk);
    end
    pkt_if.valid     <= 1'b1;
    pkt_if.req_type  <= req;
    pkt_if.data_byte <= b;
    do @(posedge clk); while (!pkt_if.ready);
  endtask

  task automatic send_packet(input logic [ByteW-1:0] status, input logic [ByteW-1:0] xb,
                             input logic [ByteW-1:0] yb);
    send_item(REQ_BYTE, status);
    send_item(REQ_BYTE, xb);
    send_item(REQ_BYTE, yb);
  endtask

  // Hold the input and wait until every predicted report has come back
  task automatic drain_results();
    @(negedge clk);
    pkt_if.valid <= 1'b0;
    while (cursor_reports_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_edge(input logic [CfgIdxW-1:0] idx, input logic [CoordW-1:0] val);
    @(negedge clk);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= val;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_edges(input logic [CoordW-1:0] max_x, input logic [CoordW-1:0] max_y,
                           input logic [CoordW-1:0] lo);
    drain_results();
    write_edge(CFG_EDGE_MAX_X, max_x);
    write_edge(CFG_EDGE_MAX_Y, max_y);
    write_edge(CFG_EDGE_MIN, lo);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Mostly whole packets with random content, some clicks and polls, some broken packets
  task automatic drive_random_items(input int count, input bit pause_midway);
    int               sent;
    int               slot;
    int               kind;
    bit               paused;
    logic [ByteW-1:0] status;
    sent   = 0;
    slot   = 0;
    paused = 1'b0;
    while (sent < count) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        // finish a broken packet with noise so the next one lines up
        while (slot != 0) begin
          send_item(REQ_BYTE, ByteW'($urandom_range(255)));
          slot = (slot + 1) % 3;
          sent++;
        end
        status = ($urandom_range(4) == 0) ? CLICK_STATUS : ByteW'($urandom_range(255));
        send_item(REQ_BYTE, status);
        if ($urandom_range(19) == 0) begin
          send_item(REQ_POLL, ByteW'($urandom_range(255)));
          sent++;
        end
        send_item(REQ_BYTE, ByteW'($urandom_range(255)));
        send_item(REQ_BYTE, ByteW'($urandom_range(255)));
        sent += 3;
      end else if (kind < 90) begin
        send_item(REQ_POLL, ByteW'($urandom_range(255)));
        sent++;
      end else begin
        send_item(REQ_BYTE, ByteW'($urandom_range(255)));
        slot = (slot + 1) % 3;
        sent++;
      end
      if (pause_midway && !paused && sent >= count / 2) begin
        paused = 1'b1;
        drain_results();
      end
    end
  endtask

  task automatic test_reset_values();
    // nothing pending and the cursor at the origin
    send_item(REQ_POLL, 8'h00);
  endtask

  task automatic test_directed_packets();
    // move down and right into the first rectangle
    send_packet(8'h20, 8'd100, 8'h9C);
    // click there; the upward move goes below zero and is rejected
    send_packet(CLICK_STATUS, 8'h00, 8'h88);
    // largest positive x step, out of every rectangle
    send_packet(8'h20, 8'hFF, 8'h88);
    // click outside all rectangles keeps the pending code
    send_packet(CLICK_STATUS, 8'h00, 8'h00);
    // poll in the middle of a packet; largest negative x step
    send_item(REQ_BYTE, 8'h30);
    send_item(REQ_POLL, 8'hFF);
    send_item(REQ_BYTE, 8'h00);
    send_item(REQ_BYTE, 8'hB0);
    // repeated clicks overwrite the pending code
    send_packet(CLICK_STATUS, 8'hFF, 8'h00);
    send_packet(8'h00, 8'h50, 8'h00);
    send_packet(CLICK_STATUS, 8'h00, 8'h00);
    send_item(REQ_POLL, 8'h00);
  endtask

  task automatic test_edge_registers();
    // widest window
    set_edges(10'd1023, 10'd1023, 10'd0);
    drive_random_items(40, 1'b0);
    // all edges at zero reject everything
    set_edges(10'd0, 10'd0, 10'd0);
    drive_random_items(40, 1'b0);
    // inverted edges
    set_edges(10'd100, 10'd100, 10'd1023);
    drive_random_items(40, 1'b0);
    // degenerate window with no coordinate strictly inside
    set_edges(10'd400, 10'd300, 10'd399);
    drive_random_items(40, 1'b0);
    // narrow window
    set_edges(10'd600, 10'd500, 10'd200);
    drive_random_items(40, 1'b0);
  endtask

  task automatic test_random_traffic();
    set_idling(0, 0);
    set_edges(EDGE_MAX_X_RST, EDGE_MAX_Y_RST, EDGE_MIN_RST);
    drive_random_items(450, 1'b1);
    set_idling(67, 0);
    set_edges(10'd1023, 10'd1023, 10'd0);
    drive_random_items(450, 1'b0);
    set_idling(0, 67);
    set_edges(CoordW'($urandom_range(1023, 300)), CoordW'($urandom_range(1023, 300)),
              CoordW'($urandom_range(20)));
    drive_random_items(450, 1'b0);
    set_idling(12, 12);
    set_edges(EDGE_MAX_X_RST, EDGE_MAX_Y_RST, EDGE_MIN_RST);
    drive_random_items(450, 1'b0);
  endtask

  initial begin
    rst              = 1'b1;
    pkt_if.valid     = 1'b0;
    pkt_if.req_type  = REQ_BYTE;
    pkt_if.data_byte = '0;
    res_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.reg_index = CFG_EDGE_MAX_X;
    cfg_if.wdata     = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_directed_packets();
    test_edge_registers();
    test_random_traffic();

    // let the last reports land, then wait for anything stray
    drain_results();
    repeat (4) @(posedge clk);
    if (cursor_errors == 0 && cursor_reports_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
